// ===== rtl/c0ls_pkg.sv =====
// Package for the C0 lexical scanner: token kinds, scan modes, error codes,
// result record type and character class helpers. No dependencies.
package c0ls_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_ZERO, M_CQ, M_CB, M_STR, M_EQ, M_LT, M_GT, M_BANG
    } scan_mode_t;

    localparam logic [5:0] K_IDENT = 6'd14;
    localparam logic [5:0] K_NUM   = 6'd15;
    localparam logic [5:0] K_CHAR  = 6'd16;
    localparam logic [5:0] K_STR   = 6'd17;
    localparam logic [5:0] K_ASSIGN = 6'd18;
    localparam logic [5:0] K_LT    = 6'd23;
    localparam logic [5:0] K_LE    = 6'd24;
    localparam logic [5:0] K_GT    = 6'd25;
    localparam logic [5:0] K_GE    = 6'd26;
    localparam logic [5:0] K_NE    = 6'd27;
    localparam logic [5:0] K_EQ    = 6'd28;
    localparam logic [5:0] K_END   = 6'd38;
    localparam logic [5:0] K_ERR   = 6'd39;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_LEADZ   = 3'd1;
    localparam logic [2:0] E_BADCHAR = 3'd2;
    localparam logic [2:0] E_NOQUOTE = 3'd3;
    localparam logic [2:0] E_BADSTR  = 3'd4;
    localparam logic [2:0] E_BANG    = 3'd5;
    localparam logic [2:0] E_UNEXP   = 3'd6;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  length;
        logic [30:0] value;
        logic [2:0]  err;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Single character symbols; 6'h3f means none
    function automatic logic [5:0] single_symbol(input logic [7:0] c);
        case (c)
            8'h2b: return 6'd19;
            8'h2d: return 6'd20;
            8'h2a: return 6'd21;
            8'h2f: return 6'd22;
            8'h28: return 6'd29;
            8'h29: return 6'd30;
            8'h5b: return 6'd31;
            8'h5d: return 6'd32;
            8'h7b: return 6'd33;
            8'h7d: return 6'd34;
            8'h2c: return 6'd35;
            8'h3a: return 6'd36;
            8'h3b: return 6'd37;
            default: return 6'h3f;
        endcase
    endfunction

endpackage

// ===== rtl/c0_lexical_scanner_top.sv =====
// C0 lexical scanner top level: input beat register, scanner core and a
// four-slot result queue. Depends on c0ls_pkg and c0ls_core.
//
// One source byte per cycle enters on the s_ channel; each byte gives zero,
// one or two tokens. Each byte passes the input beat register, then the result
// queue on its way out. A byte is taken every cycle while the result queue
// has room for two tokens; a byte that yields two tokens drains as two output
// beats, so the output port sets the rate then. Line numbers are the line
// count as it stands when the byte arrives, before any newline in it is counted.
module c0_lexical_scanner_top
    import c0ls_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = 8,
    parameter int NUMBER_BITS     = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_kind[5:0], token_length[13:6], token_value[44:14], line_number[60:45],
    // error_code[63:61]
    output logic [63:0] m_tdata,
    output logic        m_tlast
);
    typedef struct packed {
        token_t      tok;
        logic [15:0] line;
        logic        last;
    } res_t;

    logic        in_v_reg;
    logic [7:0]  in_c_reg;
    logic        step;
    logic [1:0]  count;
    token_t      tok0, tok1;
    logic [15:0] line_now;
    res_t        q_reg [0:3];
    logic [1:0]  rd_reg, wr_reg;
    logic [2:0]  fill_reg, fill_next;
    logic        pop;

    // Advance the input register when the queue can take two tokens
    assign step = in_v_reg && (fill_reg <= 3'd2 || (fill_reg == 3'd3 && pop));
    assign s_tready = !in_v_reg || step;
    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) in_v_reg <= 1'b0;
        else if (s_tready) in_v_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) in_c_reg <= s_tdata;
    end

    c0ls_core #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .NUMBER_BITS(NUMBER_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step), .in_char(in_c_reg),
        .count(count), .tok0(tok0), .tok1(tok1), .line_now(line_now));

    // Result queue; line count before the byte applies to both tokens
    always_ff @(posedge aclk) begin
        if (step && count != 2'd0) begin
            q_reg[wr_reg] <= '{tok0, line_now, count == 2'd1};
            if (count == 2'd2) q_reg[wr_reg + 2'd1] <= '{tok1, line_now, 1'b1};
        end
    end

    assign fill_next = fill_reg + (step ? {1'b0, count} : 3'd0) - {2'b00, pop};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 2'd0; wr_reg <= 2'd0; fill_reg <= 3'd0;
        end else begin
            if (step) wr_reg <= wr_reg + count;
            if (pop) rd_reg <= rd_reg + 2'd1;
            fill_reg <= fill_next;
        end
    end

    assign m_tvalid = fill_reg != 3'd0;
    assign m_tdata  = {q_reg[rd_reg].tok.err, q_reg[rd_reg].line, q_reg[rd_reg].tok.value,
                       q_reg[rd_reg].tok.length, q_reg[rd_reg].tok.kind};
    assign m_tlast  = q_reg[rd_reg].last;

    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= 3'd4)
        else $error("result queue overfilled");
    a_no_step_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 3'd4) |-> !step) else $error("step with full queue");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> count != 2'd3) else $error("bad token count");
endmodule

// ===== rtl/c0ls_keyword.sv =====
// Keyword matcher: compares the buffered word against the 14 C0 keywords.
// Depends on c0ls_pkg.
module c0ls_keyword
    import c0ls_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = 8
) (
    input  logic [KEYWORD_MAX_LEN*8-1:0] word,
    input  logic [7:0]                   length,
    output logic [5:0]                   kind
);
    function automatic logic hit(input logic [KEYWORD_MAX_LEN*8-1:0] w,
                                 input logic [7:0] l, input logic [63:0] txt,
                                 input logic [7:0] kl);
        logic ok;
        ok = (l == kl);
        for (int i = 0; i < 8; i++) begin
            if (i < int'(kl) && w[i*8 +: 8] != txt[i*8 +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    // Text packed first character lowest
    always_comb begin
        kind = K_IDENT;
        if (length <= 8'(KEYWORD_MAX_LEN)) begin
            if (hit(word, length, 64'h6e69616d, 8'd4)) kind = 6'd0;
            else if (hit(word, length, 64'h746e69, 8'd3)) kind = 6'd1;
            else if (hit(word, length, 64'h72616863, 8'd4)) kind = 6'd2;
            else if (hit(word, length, 64'h74736e6f63, 8'd5)) kind = 6'd3;
            else if (hit(word, length, 64'h64696f76, 8'd4)) kind = 6'd4;
            else if (hit(word, length, 64'h6669, 8'd2)) kind = 6'd5;
            else if (hit(word, length, 64'h65736c65, 8'd4)) kind = 6'd6;
            else if (hit(word, length, 64'h686374697773, 8'd6)) kind = 6'd7;
            else if (hit(word, length, 64'h65736163, 8'd4)) kind = 6'd8;
            else if (hit(word, length, 64'h746c7561666564, 8'd7)) kind = 6'd9;
            else if (hit(word, length, 64'h726f66, 8'd3)) kind = 6'd10;
            else if (hit(word, length, 64'h66746e697270, 8'd6)) kind = 6'd11;
            else if (hit(word, length, 64'h666e616373, 8'd5)) kind = 6'd12;
            else if (hit(word, length, 64'h6e7275746572, 8'd6)) kind = 6'd13;
        end
    end
endmodule

// ===== rtl/c0ls_core.sv =====
// Scanner core: mode register, lexeme state and the per-character step that
// yields up to two tokens. Depends on c0ls_pkg and c0ls_keyword.
module c0ls_core
    import c0ls_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = 8,
    parameter int NUMBER_BITS     = 31
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_char,
    output logic [1:0] count,
    output token_t     tok0,
    output token_t     tok1,
    output logic [15:0] line_now
);
    localparam logic [NUMBER_BITS-1:0] NMAX = '1;
    localparam int KLW = $clog2(KEYWORD_MAX_LEN);

    scan_mode_t mode_reg, mode_next;
    logic [7:0] len_reg, len_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic [7:0] held_reg, held_next;
    logic [15:0] line_reg, line_next;
    logic [KEYWORD_MAX_LEN*8-1:0] word_reg, word_next;
    logic [5:0] kw_kind;
    logic [NUMBER_BITS+3:0] acc_x10;

    c0ls_keyword #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
        .word(word_reg), .length(len_reg), .kind(kw_kind));

    assign line_now = line_reg;
    assign acc_x10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                     + (NUMBER_BITS+4)'(in_char[3:0]);

    always_comb begin
        token_t a;
        logic restart;
        logic [5:0] s;
        mode_next = mode_reg; len_next = len_reg; acc_next = acc_reg;
        held_next = held_reg; line_next = line_reg; word_next = word_reg;
        count = 2'd0; restart = 1'b0;
        a = '{kind: K_ERR, length: 8'd0, value: '0, err: E_NONE};
        tok0 = a; tok1 = a;
        // Pending-token step
        case (mode_reg)
            M_IDENT: begin
                if (is_letter(in_char) || is_digit(in_char)) begin
                    if (len_reg < 8'(KEYWORD_MAX_LEN))
                        word_next[len_reg[KLW-1:0]*8 +: 8] = in_char;
                    if (len_reg != 8'hff) len_next = len_reg + 8'd1;
                end else begin
                    tok0 = '{kw_kind, len_reg, 31'd0, E_NONE}; count = 2'd1; restart = 1'b1;
                end
            end
            M_NUM: begin
                if (is_digit(in_char)) begin
                    if (acc_x10 > (NUMBER_BITS+4)'(NMAX)) acc_next = NMAX;
                    else acc_next = acc_x10[NUMBER_BITS-1:0];
                    if (len_reg != 8'hff) len_next = len_reg + 8'd1;
                end else begin
                    tok0 = '{K_NUM, len_reg, 31'(acc_reg), E_NONE};
                    count = 2'd1; restart = 1'b1;
                end
            end
            M_ZERO: begin
                if (is_digit(in_char)) tok0 = '{K_ERR, 8'd1, 31'd0, E_LEADZ};
                else tok0 = '{K_NUM, 8'd1, 31'd0, E_NONE};
                count = 2'd1; restart = 1'b1;
            end
            M_CQ: begin
                if (is_letter(in_char) || is_digit(in_char) || in_char == 8'h2b
                    || in_char == 8'h2d || in_char == 8'h2a || in_char == 8'h2f) begin
                    held_next = in_char; len_next = 8'd2; mode_next = M_CB;
                end else begin
                    tok0 = '{K_ERR, 8'd1, 31'd0, E_BADCHAR}; count = 2'd1; restart = 1'b1;
                end
            end
            M_CB: begin
                if (in_char == 8'h27) begin
                    mode_next = M_IDLE;
                    tok0 = '{K_CHAR, 8'd3, {23'd0, held_reg}, E_NONE}; count = 2'd1;
                end else begin
                    tok0 = '{K_ERR, 8'd2, 31'd0, E_NOQUOTE}; count = 2'd1; restart = 1'b1;
                end
            end
            M_STR: begin
                if (in_char == 8'h22) begin
                    if (len_reg != 8'hff) len_next = len_reg + 8'd1;
                    mode_next = M_IDLE;
                    tok0 = '{K_STR, len_next, 31'd0, E_NONE}; count = 2'd1;
                end else if (in_char == 8'd32 || in_char == 8'd33
                             || (in_char >= 8'd35 && in_char <= 8'd126)) begin
                    if (len_reg != 8'hff) len_next = len_reg + 8'd1;
                end else if (in_char == 8'd0) begin
                    tok0 = '{K_ERR, len_reg, 31'd0, E_NOQUOTE}; count = 2'd1; restart = 1'b1;
                end else begin
                    tok0 = '{K_ERR, len_reg, 31'd0, E_BADSTR}; count = 2'd1;
                    if (in_char == 8'h0a && line_reg != 16'hffff) line_next = line_reg + 16'd1;
                end
            end
            M_EQ, M_LT, M_GT, M_BANG: begin
                count = 2'd1;
                if (in_char == 8'h3d) begin
                    mode_next = M_IDLE;
                    tok0.length = 8'd2;
                    case (mode_reg)
                        M_EQ: tok0.kind = K_EQ;
                        M_LT: tok0.kind = K_LE;
                        M_GT: tok0.kind = K_GE;
                        default: tok0.kind = K_NE;
                    endcase
                end else begin
                    restart = 1'b1;
                    tok0.length = 8'd1;
                    case (mode_reg)
                        M_EQ: tok0.kind = K_ASSIGN;
                        M_LT: tok0.kind = K_LT;
                        M_GT: tok0.kind = K_GT;
                        default: begin
                            tok0.kind = K_ERR; tok0.err = E_BANG;
                        end
                    endcase
                end
            end
            default: restart = 1'b1;
        endcase
        // Scan the character afresh from between tokens
        if (restart) begin
            a = '{K_ERR, 8'd1, 31'd0, E_NONE};
            mode_next = M_IDLE; len_next = 8'd1;
            s = single_symbol(in_char);
            if (is_letter(in_char)) begin
                word_next[7:0] = in_char; mode_next = M_IDENT;
            end else if (is_digit(in_char) && in_char != 8'h30) begin
                acc_next = NUMBER_BITS'(in_char[3:0]); mode_next = M_NUM;
            end else if (in_char == 8'h30) mode_next = M_ZERO;
            else if (in_char == 8'h27) mode_next = M_CQ;
            else if (in_char == 8'h22) mode_next = M_STR;
            else if (in_char == 8'h3d) mode_next = M_EQ;
            else if (in_char == 8'h3c) mode_next = M_LT;
            else if (in_char == 8'h3e) mode_next = M_GT;
            else if (in_char == 8'h21) mode_next = M_BANG;
            else if (in_char == 8'h20 || in_char == 8'h09 || in_char == 8'h0a) begin
                len_next = 8'd0;
                if (in_char == 8'h0a && line_reg != 16'hffff) line_next = line_reg + 16'd1;
            end else begin
                if (in_char == 8'd0) begin
                    len_next = 8'd0; a.kind = K_END; a.length = 8'd0;
                end else if (s != 6'h3f) a.kind = s;
                else a.err = E_UNEXP;
                if (count == 2'd0) begin
                    tok0 = a; count = 2'd1;
                end else begin
                    tok1 = a; count = 2'd2;
                end
            end
        end
    end

    // Hold state except on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE; len_reg <= 8'd0; acc_reg <= '0;
            held_reg <= 8'd0; line_reg <= 16'd1;
        end else if (step) begin
            mode_reg <= mode_next; len_reg <= len_next; acc_reg <= acc_next;
            held_reg <= held_next; line_reg <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) word_reg <= word_next;
    end
endmodule
